FILE: src/dbcw_pkg.sv
// ----------------------------------------------------------------------------
// dbcw_pkg
// Payload types, request codes and small arithmetic helpers for the
// delay-based congestion window block.
// ----------------------------------------------------------------------------
`default_nettype none

package dbcw_pkg;

    localparam logic [1:0] REQ_ACK   = 2'd0;
    localparam logic [1:0] REQ_LOSS  = 2'd1;
    localparam logic [1:0] REQ_UNDO  = 2'd2;
    localparam logic [1:0] REQ_OTHER = 2'd3;

    localparam logic [31:0] WIN_MAX       = 32'hFFFF_FFFF;
    localparam logic [31:0] WIN_RESET     = 32'd10;
    localparam logic [31:0] THR_RESET     = 32'hFFFF_FFFF;
    localparam logic [31:0] THR_FLOOR     = 32'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] rtt_sample_us;
        logic [15:0]        acked_count;
    } item_t;

    typedef struct packed {
        logic [31:0] window;
        logic [31:0] threshold;
        logic [31:0] reduced_threshold;
        logic [30:0] lowest_rtt_us;
        logic        in_slow_start;
    } result_t;

    // Saturating 32-bit add
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            sat_add = sum[32] ? WIN_MAX : sum[31:0];
        end
    endfunction

    // max(floor(3w/4), 2), with 3w held in 34 bits so it never wraps
    function automatic logic [31:0] reduce_window(input logic [31:0] w);
        logic [33:0] triple;
        logic [31:0] quarter;
        begin
            triple  = {2'b00, w} + {1'b0, w, 1'b0};
            quarter = triple[33:2];
            reduce_window = (quarter < THR_FLOOR) ? THR_FLOOR : quarter;
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/delay_based_congestion_window.sv
// ----------------------------------------------------------------------------
// delay_based_congestion_window
// Congestion window, slow-start threshold and RTT tracking for one connection.
// ----------------------------------------------------------------------------
//
// One item is processed at a time. A loss, undo or other event passes through
// accept, execute and finish; an ack that does not divide adds a check state
// before finish, and an ack in congestion avoidance that grows the window
// also runs the bit-serial divider, which forms acked/window one quotient bit
// per cycle, and then an add state. The result sits in an output register,
// so the next item is taken while a finished result still waits to be
// transferred. Writing initial_window or initial_threshold over the
// APB port also reloads the live window or threshold; write only while idle.
//
`default_nettype none

module delay_based_congestion_window (
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire dbcw_pkg::item_t  item,

    output logic                  result_valid,
    input  wire logic             result_stall,
    output dbcw_pkg::result_t     result,

    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    import dbcw_pkg::*;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    localparam int          DIV_STEPS = 16;
    localparam logic [3:0]  DIV_LAST  = 4'(DIV_STEPS - 1);

    // Configuration and connection state
    logic [31:0] init_window_reg;
    logic [31:0] init_threshold_reg;
    logic [31:0] cur_window_reg,    cur_window_next;
    logic [31:0] cur_threshold_reg, cur_threshold_next;
    logic [31:0] saved_window_reg,  saved_window_next;
    logic [30:0] lowest_rtt_reg,    lowest_rtt_next;
    logic [30:0] latest_rtt_reg,    latest_rtt_next;

    // Sequencer and held item
    logic [2:0]  state_reg, state_next;
    item_t       item_reg;

    // Divider: remainder and the dividend that turns into the quotient
    logic [15:0] rem_reg,  rem_next;
    logic [15:0] quot_reg, quot_next;
    logic [3:0]  step_reg, step_next;

    // Result register
    logic        result_valid_reg, result_valid_next;
    result_t     result_reg,       result_next;

    // Datapath helpers
    logic        cfg_write;
    logic        sample_ok;
    logic [31:0] divisor;
    logic [16:0] trial;
    logic        trial_ge;
    logic [16:0] trial_diff;
    logic [31:0] latest_inc;
    logic [34:0] latest_x5;
    logic [34:0] lowest_x6;
    logic        under_target;
    logic        slow_start;
    logic        out_free;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = paddr[2] ? init_threshold_reg : init_window_reg;

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || !result_stall;

    assign sample_ok  = (item_reg.rtt_sample_us != 32'sd0) && !item_reg.rtt_sample_us[31];
    assign slow_start = (cur_window_reg < cur_threshold_reg);

    // latest < floor(6*min/5)  <=>  5*(latest+1) <= 6*min
    assign latest_inc   = {1'b0, latest_rtt_reg} + 32'd1;
    assign latest_x5    = {3'b000, latest_inc} + {1'b0, latest_inc, 2'b00};
    assign lowest_x6    = {3'b000, lowest_rtt_reg, 1'b0} + {2'b00, lowest_rtt_reg, 2'b00};
    assign under_target = (latest_x5 <= lowest_x6);

    // One restoring-division step: shift in the next dividend bit
    assign divisor    = (cur_window_reg == 32'd0) ? 32'd1 : cur_window_reg;
    assign trial      = {rem_reg, quot_reg[15]};
    assign trial_ge   = ({15'd0, trial} >= divisor);
    assign trial_diff = trial - divisor[16:0];

    always_comb
    begin
        state_next         = state_reg;
        cur_window_next    = cur_window_reg;
        cur_threshold_next = cur_threshold_reg;
        saved_window_next  = saved_window_reg;
        lowest_rtt_next    = lowest_rtt_reg;
        latest_rtt_next    = latest_rtt_reg;
        rem_next           = rem_reg;
        quot_next          = quot_reg;
        step_next          = step_reg;
        result_valid_next  = result_valid_reg;
        result_next        = result_reg;

        // Drop the result once the consumer has taken it
        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                    state_next = ST_EXEC;
            end

            ST_EXEC:
            begin
                state_next = ST_FIN;
                unique case (item_reg.req_type)
                    REQ_ACK:
                    begin
                        // Record a positive sample and track the minimum
                        if (sample_ok)
                        begin
                            latest_rtt_next = item_reg.rtt_sample_us[30:0];
                            if (lowest_rtt_reg == 31'd0 ||
                                item_reg.rtt_sample_us[30:0] < lowest_rtt_reg)
                                lowest_rtt_next = item_reg.rtt_sample_us[30:0];
                        end
                        state_next = ST_CHECK;
                    end
                    REQ_LOSS:
                    begin
                        saved_window_next  = cur_window_reg;
                        cur_threshold_next = reduce_window(cur_window_reg);
                        cur_window_next    = 32'd1;
                        lowest_rtt_next    = 31'd0;
                    end
                    REQ_UNDO:
                    begin
                        if (saved_window_reg > cur_window_reg)
                            cur_window_next = saved_window_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end

            ST_CHECK:
            begin
                rem_next   = 16'd0;
                quot_next  = item_reg.acked_count;
                step_next  = 4'd0;
                state_next = ST_FIN;
                priority if (item_reg.acked_count == 16'd0)
                    state_next = ST_FIN;
                else if (slow_start)
                    cur_window_next = sat_add(cur_window_reg, {16'd0, item_reg.acked_count});
                else if (lowest_rtt_reg == 31'd0 || under_target)
                    state_next = ST_DIV;
                else
                    state_next = ST_FIN;
            end

            ST_DIV:
            begin
                rem_next  = trial_ge ? trial_diff[15:0] : trial[15:0];
                quot_next = {quot_reg[14:0], trial_ge};
                step_next = step_reg + 4'd1;
                if (step_reg == DIV_LAST)
                    state_next = ST_ADD;
            end

            ST_ADD:
            begin
                cur_window_next = sat_add(cur_window_reg, {16'd0, quot_reg});
                state_next      = ST_FIN;
            end

            ST_FIN:
            begin
                // Hold until the result register is free
                if (out_free)
                begin
                    result_valid_next             = 1'b1;
                    result_next.window            = cur_window_reg;
                    result_next.threshold         = cur_threshold_reg;
                    result_next.reduced_threshold = reduce_window(cur_window_reg);
                    result_next.lowest_rtt_us     = lowest_rtt_reg;
                    result_next.in_slow_start     = slow_start;
                    state_next                    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Configuration writes also reload the live window and threshold
        if (cfg_write)
        begin
            if (paddr[2])
                cur_threshold_next = pwdata;
            else
                cur_window_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            init_window_reg    <= WIN_RESET;
            init_threshold_reg <= THR_RESET;
            cur_window_reg     <= WIN_RESET;
            cur_threshold_reg  <= THR_RESET;
            saved_window_reg   <= 32'd0;
            lowest_rtt_reg     <= 31'd0;
            latest_rtt_reg     <= 31'd0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            cur_window_reg    <= cur_window_next;
            cur_threshold_reg <= cur_threshold_next;
            saved_window_reg  <= saved_window_next;
            lowest_rtt_reg    <= lowest_rtt_next;
            latest_rtt_reg    <= latest_rtt_next;
            result_valid_reg  <= result_valid_next;
            if (cfg_write)
            begin
                if (paddr[2])
                    init_threshold_reg <= pwdata;
                else
                    init_window_reg <= pwdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && item_valid)
            item_reg <= item;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        step_reg   <= step_next;
        result_reg <= result_next;
    end

endmodule

`default_nettype wire
